// ===== hw/rtl/mrhs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrhs_pkg
// Shared types and fixed field widths for the maximal rectangle histogram
// stack block.
// ----------------------------------------------------------------------------
package mrhs_pkg;

  // fixed field widths
  localparam int CELL_W     = 8;
  localparam int HEIGHT_W   = 16;
  localparam int AREA_W     = 24;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_ADDR_W = 1;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
  localparam logic [AREA_W-1:0]   AREA_MAX   = '1;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_COLS_IN_USE = 1'b0,
    CFG_ROWS_IN_USE = 1'b1
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HEIGHT = 5'b00010,
    S_CMP    = 5'b00100,
    S_SCORE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // stack commands
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

// ===== hw/rtl/maximal_rectangle_histogram_stack.sv =====
// ----------------------------------------------------------------------------
// maximal_rectangle_histogram_stack
// Largest rectangle over a streamed matrix, one histogram stack scan per row.
// ----------------------------------------------------------------------------
// An item steps through accept, height read and update, then push, plus a
// pop and score for each column popped; the last item of a row also flushes
// the stack, popping and scoring every entry. A new cell is taken only once
// the last is through. The last item of a matrix loads the result register,
// waiting while one is still held; the shared pop and score path sets the rate.
// Reset clears heights (through a fill count), stack, best area, counters; sizes 256.
module maximal_rectangle_histogram_stack #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  // cell_value [7:0]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  // largest_area [23:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,
  input  logic                            cfg_we,
  input  logic [mrhs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mrhs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int HW     = mrhs_pkg::HEIGHT_W;
  localparam int PROD_W = HW + CNT_W;

  mrhs_pkg::state_t   state;
  mrhs_pkg::state_t   state_next;
  mrhs_pkg::stk_cmd_t stk_cmd;

  logic [mrhs_pkg::CFG_DATA_W-1:0] cols_in_use;
  logic [mrhs_pkg::CFG_DATA_W-1:0] rows_in_use;
  logic [CNT_W-1:0]                cols_eff;
  logic [RCNT_W-1:0]               rows_eff;

  logic [HW-1:0]              heights [MAX_COLS];
  logic [HW-1:0]              h_rd;
  logic [mrhs_pkg::CELL_W-1:0] cell_value;
  logic [HW-1:0]              cur_h;
  logic [HW-1:0]              new_h;
  logic [HW:0]                h_sum;
  logic [CNT_W-1:0]           fill;
  logic [COL_W-1:0]           column_index;
  logic [ROW_W-1:0]           row_index;
  logic                       flush;
  logic [mrhs_pkg::AREA_W-1:0] best_area;
  logic [PROD_W-1:0]          prod;
  logic [mrhs_pkg::AREA_W-1:0] area_sat;

  logic             top_valid;
  logic [COL_W-1:0] top_col;
  logic [COL_W-1:0] top_start;
  logic [HW-1:0]    top_h;
  logic [COL_W-1:0] push_start;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] col_plus;
  logic             row_last_col;
  logic             do_pop;
  logic             out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= mrhs_pkg::CFG_DATA_W'(256);
      rows_in_use <= mrhs_pkg::CFG_DATA_W'(256);
    end else if (cfg_we) begin
      case (cfg_addr)
        mrhs_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_data;
        mrhs_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cols_in_use == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(cols_in_use);
    end
    if (rows_in_use == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(rows_in_use);
    end
  end

  // column heights memory
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      h_rd <= heights[column_index];
    end
    if (state == mrhs_pkg::S_HEIGHT) begin
      heights[column_index] <= new_h;
    end
  end

  // new height: columns past the fill count were not written this matrix
  always_comb begin
    h_sum = {1'b0, ((CNT_W'(column_index) < fill) ? h_rd : HW'(0))} +
            (HW + 1)'(cell_value);
    if (row_index == '0 || cell_value == '0) begin
      new_h = HW'(cell_value);
    end else if (h_sum[HW]) begin
      new_h = mrhs_pkg::HEIGHT_MAX;
    end else begin
      new_h = h_sum[HW-1:0];
    end
  end

  // scan position and pop decision
  assign col_plus     = CNT_W'(column_index) + CNT_W'(1);
  assign pos          = flush ? col_plus : CNT_W'(column_index);
  assign row_last_col = !(col_plus < cols_eff);
  assign do_pop       = top_valid && (flush || cur_h < top_h);
  assign push_start   = top_valid ? COL_W'(CNT_W'(top_col) + CNT_W'(1)) : '0;
  assign out_free     = !m_tvalid || m_tready;
  assign s_tready     = (state == mrhs_pkg::S_IDLE);

  // stack commands
  always_comb begin
    stk_cmd      = '0;
    if (state == mrhs_pkg::S_CMP) begin
      stk_cmd.pop  = do_pop;
      stk_cmd.push = !do_pop && !flush;
    end
  end

  mrhs_stack #(
    .MAX_COLS(MAX_COLS),
    .COL_W   (COL_W)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (stk_cmd),
    .push_col  (column_index),
    .push_start(push_start),
    .push_h    (cur_h),
    .top_valid (top_valid),
    .top_col   (top_col),
    .top_start (top_start),
    .top_h     (top_h)
  );

  // saturated area of the popped column
  assign area_sat = (32'(prod) > 32'(mrhs_pkg::AREA_MAX)) ? mrhs_pkg::AREA_MAX :
                    mrhs_pkg::AREA_W'(prod);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrhs_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = mrhs_pkg::S_HEIGHT;
        end
      end
      mrhs_pkg::S_HEIGHT: state_next = mrhs_pkg::S_CMP;
      mrhs_pkg::S_CMP: begin
        if (do_pop) begin
          state_next = mrhs_pkg::S_SCORE;
        end else if (!flush) begin
          state_next = row_last_col ? mrhs_pkg::S_CMP : mrhs_pkg::S_IDLE;
        end else if (RCNT_W'(row_index) + RCNT_W'(1) < rows_eff) begin
          state_next = mrhs_pkg::S_IDLE;
        end else begin
          state_next = mrhs_pkg::S_DONE;
        end
      end
      mrhs_pkg::S_SCORE: state_next = mrhs_pkg::S_CMP;
      mrhs_pkg::S_DONE: begin
        if (out_free) begin
          state_next = mrhs_pkg::S_IDLE;
        end
      end
      default: state_next = mrhs_pkg::S_IDLE;
    endcase
  end

  // item payload and pop product
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cell_value <= s_tdata;
    end
    if (state == mrhs_pkg::S_HEIGHT) begin
      cur_h <= new_h;
    end
    if (state == mrhs_pkg::S_CMP && do_pop) begin
      prod <= PROD_W'(top_h) * PROD_W'(pos - CNT_W'(top_start));
    end
  end

  // sequencer and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mrhs_pkg::S_IDLE;
      column_index <= '0;
      row_index    <= '0;
      fill         <= '0;
      flush        <= 1'b0;
      best_area    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      // result valid: load on the final step, drop once taken
      if (state == mrhs_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        mrhs_pkg::S_HEIGHT: begin
          if (!(CNT_W'(column_index) < fill)) begin
            fill <= col_plus;
          end
        end
        mrhs_pkg::S_CMP: begin
          if (!do_pop) begin
            if (!flush) begin
              if (row_last_col) begin
                flush <= 1'b1;
              end else begin
                column_index <= column_index + COL_W'(1);
              end
            end else begin
              flush        <= 1'b0;
              column_index <= '0;
              if (RCNT_W'(row_index) + RCNT_W'(1) < rows_eff) begin
                row_index <= row_index + ROW_W'(1);
              end
            end
          end
        end
        mrhs_pkg::S_SCORE: begin
          if (area_sat > best_area) begin
            best_area <= area_sat;
          end
        end
        mrhs_pkg::S_DONE: begin
          if (out_free) begin
            m_tdata   <= best_area;
            best_area <= '0;
            row_index <= '0;
            fill      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mrhs_stack.sv =====
// ----------------------------------------------------------------------------
// mrhs_stack
// Histogram stack: top entry in registers, the entries below it in a memory.
// An entry holds its column, the first column it extends left to, and height.
// ----------------------------------------------------------------------------
module mrhs_stack #(
  parameter int MAX_COLS = 256,
  parameter int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mrhs_pkg::stk_cmd_t            cmd,
  input  logic [COL_W-1:0]              push_col,
  input  logic [COL_W-1:0]              push_start,
  input  logic [mrhs_pkg::HEIGHT_W-1:0] push_h,
  output logic                          top_valid,
  output logic [COL_W-1:0]              top_col,
  output logic [COL_W-1:0]              top_start,
  output logic [mrhs_pkg::HEIGHT_W-1:0] top_h
);

  localparam int ENT_W = 2 * COL_W + mrhs_pkg::HEIGHT_W;

  logic [ENT_W-1:0] mem [MAX_COLS];
  logic [ENT_W-1:0] rd_data;
  logic [ENT_W-1:0] top_reg;
  logic [ENT_W-1:0] top_ent;
  logic [COL_W-1:0] mem_cnt;
  logic             load_pending;

  // after a pop the new top comes straight from the memory read register
  assign top_ent   = load_pending ? rd_data : top_reg;
  assign top_col   = top_ent[ENT_W-1 -: COL_W];
  assign top_start = top_ent[mrhs_pkg::HEIGHT_W +: COL_W];
  assign top_h     = top_ent[mrhs_pkg::HEIGHT_W-1:0];

  // entries below the top
  always_ff @(posedge clk) begin
    if (cmd.push && top_valid) begin
      mem[mem_cnt] <= top_ent;
    end
    if (cmd.pop) begin
      rd_data <= mem[mem_cnt - COL_W'(1)];
    end
  end

  // top register and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      top_valid    <= 1'b0;
      mem_cnt      <= '0;
      load_pending <= 1'b0;
    end else if (cmd.push) begin
      top_reg      <= {push_col, push_start, push_h};
      top_valid    <= 1'b1;
      load_pending <= 1'b0;
      if (top_valid) begin
        mem_cnt <= mem_cnt + COL_W'(1);
      end
    end else if (cmd.pop) begin
      top_valid    <= (mem_cnt != '0);
      load_pending <= 1'b1;
      if (mem_cnt != '0) begin
        mem_cnt <= mem_cnt - COL_W'(1);
      end
    end else if (load_pending) begin
      top_reg      <= rd_data;
      load_pending <= 1'b0;
    end
  end

endmodule

// ===== dv/tb_maximal_rectangle_histogram_stack.sv =====
// ----------------------------------------------------------------------------
// tb_maximal_rectangle_histogram_stack
// Streams matrix cells into the block and predicts the largest rectangle area
// for each finished matrix. Matrix sizes change between phases, including
// zero, oversized and shrink-while-mid-matrix writes. Both stream sides idle
// at random.
// ----------------------------------------------------------------------------
module tb_maximal_rectangle_histogram_stack;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int ITEMS      = 1650;
  // worst single item: full pop of a row plus the row-end flush
  localparam int DRAIN      = 4 * MAX_COLS + 64;

  // expected largest area per matrix, from a histogram stack scan of each row
  class area_board;
    logic [mrhs_pkg::HEIGHT_W-1:0]   heights [MAX_COLS];
    int unsigned                     stack_cols [MAX_COLS];
    int unsigned                     depth;
    int unsigned                     col_idx;
    int unsigned                     row_idx;
    logic [mrhs_pkg::AREA_W-1:0]     best;
    logic [mrhs_pkg::CFG_DATA_W-1:0] cols_reg;
    logic [mrhs_pkg::CFG_DATA_W-1:0] rows_reg;
    logic [mrhs_pkg::AREA_W-1:0]     pending_areas [$];
    int unsigned                     errors;

    function new();
      cols_reg = 9'd256;
      rows_reg = 9'd256;
      errors   = 0;
      clear_matrix();
    endfunction

    function void clear_matrix();
      foreach (heights[i]) heights[i] = '0;
      depth   = 0;
      col_idx = 0;
      row_idx = 0;
      best    = '0;
    endfunction

    // zero acts as one, oversize acts as the maximum
    function int unsigned eff_count(logic [mrhs_pkg::CFG_DATA_W-1:0] v,
                                    int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : int'(v);
    endfunction

    function void set_reg(mrhs_pkg::cfg_idx_t idx, logic [mrhs_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        mrhs_pkg::CFG_COLS_IN_USE: cols_reg = v;
        mrhs_pkg::CFG_ROWS_IN_USE: rows_reg = v;
        default: ;
      endcase
    endfunction

    // pop the top column and score its rectangle ending at pos
    function void pop_score(int unsigned pos);
      int unsigned     top;
      int unsigned     width;
      longint unsigned area;
      top = stack_cols[depth-1];
      depth--;
      width = (depth == 0) ? pos : pos - stack_cols[depth-1] - 1;
      area = heights[top];
      area = area * width;
      if (area > mrhs_pkg::AREA_MAX) area = mrhs_pkg::AREA_MAX;
      if (area > best) best = area[mrhs_pkg::AREA_W-1:0];
    endfunction

    function void note_cell(logic [mrhs_pkg::CELL_W-1:0] cell_value);
      int unsigned ncols;
      int unsigned nrows;
      int unsigned col;
      int unsigned h;
      ncols = eff_count(cols_reg, MAX_COLS);
      nrows = eff_count(rows_reg, MAX_ROWS);
      col = col_idx % MAX_COLS;
      // column height update, zero breaks the run
      if (row_idx == 0 || cell_value == 0) begin
        h = cell_value;
      end else begin
        h = heights[col] + cell_value;
        if (h > mrhs_pkg::HEIGHT_MAX) h = mrhs_pkg::HEIGHT_MAX;
      end
      heights[col] = h[mrhs_pkg::HEIGHT_W-1:0];
      // pop taller columns, then push this one
      while (depth > 0 && h < heights[stack_cols[depth-1]]) pop_score(col);
      if (depth < MAX_COLS) begin
        stack_cols[depth] = col;
        depth++;
      end
      if (col + 1 < ncols) begin
        col_idx = col + 1;
        return;
      end
      // row end flush
      while (depth > 0) pop_score(col + 1);
      col_idx = 0;
      if (row_idx + 1 < nrows) begin
        row_idx++;
        return;
      end
      pending_areas.insert(pending_areas.size(), best);
      clear_matrix();
    endfunction

    function void check_area(logic [mrhs_pkg::AREA_W-1:0] got);
      logic [mrhs_pkg::AREA_W-1:0] want;
      if (pending_areas.size() == 0) begin
        $error("largest_area: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = pending_areas.pop_front();
      if (got !== want) begin
        $error("largest_area: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_areas.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata = '0;   // cell_value [7:0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [23:0]                     m_tdata;        // largest_area [23:0]
  logic                            cfg_we = 1'b0;
  logic [mrhs_pkg::CFG_ADDR_W-1:0] cfg_addr = mrhs_pkg::CFG_COLS_IN_USE;
  logic [mrhs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  area_board     board;
  int unsigned   cells_sent = 0;

  maximal_rectangle_histogram_stack i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // no idling on either side over a stretch in the middle
  function automatic bit steady();
    return cells_sent >= 700 && cells_sent < 1000;
  endfunction

  function automatic logic [mrhs_pkg::CELL_W-1:0] pick_cell(int unsigned zero_pct);
    if ($urandom_range(99) < zero_pct) return '0;
    case ($urandom_range(3))
      0: return 8'd255;
      1: return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [mrhs_pkg::CFG_DATA_W-1:0] big_count();
    case ($urandom_range(4))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'd511;
      default: return 9'($urandom_range(9, 511));
    endcase
  endfunction

  task automatic send_cell(input logic [mrhs_pkg::CELL_W-1:0] cell_value);
    while (!steady() && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cell_value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_cell(cell_value);
    cells_sent++;
  endtask

  task automatic load_sizes(input logic [mrhs_pkg::CFG_DATA_W-1:0] ncols,
                            input logic [mrhs_pkg::CFG_DATA_W-1:0] nrows);
    cfg_we   <= 1'b1;
    cfg_addr <= mrhs_pkg::CFG_COLS_IN_USE;
    cfg_data <= ncols;
    @(posedge clk);
    board.set_reg(mrhs_pkg::CFG_COLS_IN_USE, ncols);
    cfg_addr <= mrhs_pkg::CFG_ROWS_IN_USE;
    cfg_data <= nrows;
    @(posedge clk);
    board.set_reg(mrhs_pkg::CFG_ROWS_IN_USE, nrows);
    cfg_we <= 1'b0;
  endtask

  // stop sending, let results drain and the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_matrices(input logic [mrhs_pkg::CFG_DATA_W-1:0] ncols,
                               input logic [mrhs_pkg::CFG_DATA_W-1:0] nrows,
                               input int unsigned mats, input int unsigned tail);
    int unsigned prod;
    int unsigned zero_pct;
    settle();
    load_sizes(ncols, nrows);
    prod = board.eff_count(ncols, MAX_COLS) * board.eff_count(nrows, MAX_ROWS);
    zero_pct = $urandom_range(0, 60);
    repeat (mats * prod + tail) send_cell(pick_cell(zero_pct));
  endtask

  // result side
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        board.check_area(m_tdata);
      end
      m_tready <= steady() || ($urandom_range(99) >= 29);
    end
  end

  // main sequence
  initial begin
    int unsigned                     kind;
    int unsigned                     prod;
    int unsigned                     mats;
    int unsigned                     tail;
    logic [mrhs_pkg::CFG_DATA_W-1:0] ncols;
    logic [mrhs_pkg::CFG_DATA_W-1:0] nrows;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    settle();

    // reset sizes, then shrink columns and rows to zero mid-matrix
    send_cell(8'd3);
    send_cell(8'd0);
    send_cell(8'd255);
    send_cell(8'd255);
    send_cell(8'd7);
    send_cell(8'd1);
    send_cell(8'd200);
    send_cell(8'd200);
    send_cell(8'd0);
    send_cell(8'd9);
    settle();
    load_sizes(9'd0, 9'd256);
    send_cell(8'd6);
    settle();
    load_sizes(9'd1, 9'd0);
    send_cell(8'd255);

    // zero break and height build-up
    settle();
    load_sizes(9'd3, 9'd2);
    send_cell(8'd255);
    send_cell(8'd0);
    send_cell(8'd255);
    send_cell(8'd255);
    send_cell(8'd255);
    send_cell(8'd1);

    // falling heights pop the stack
    settle();
    load_sizes(9'd4, 9'd1);
    send_cell(8'd4);
    send_cell(8'd3);
    send_cell(8'd2);
    send_cell(8'd1);

    // all-zero matrix
    settle();
    load_sizes(9'd1, 9'd1);
    send_cell(8'd0);

    // oversized columns, then oversized rows
    send_matrices(9'd511, 9'd1, 1, 0);
    send_matrices(9'd1, 9'd300, 1, 0);

    // random sizes, mostly small, some rows left unfinished across phases
    while (cells_sent < ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 8 && cells_sent < 1200) begin
        ncols = big_count();
        nrows = 9'($urandom_range(0, 2));
      end else if (kind < 16 && cells_sent < 1200) begin
        ncols = 9'($urandom_range(0, 2));
        nrows = big_count();
      end else begin
        ncols = 9'($urandom_range(0, 9));
        nrows = 9'($urandom_range(0, 9));
      end
      prod = board.eff_count(ncols, MAX_COLS) * board.eff_count(nrows, MAX_ROWS);
      mats = (prod > 100) ? 1 : $urandom_range(1, 5);
      tail = 0;
      if (prod > 1 && $urandom_range(99) < 30)
        tail = $urandom_range(1, (prod - 1 < 40) ? prod - 1 : 40);
      send_matrices(ncols, nrows, mats, tail);
    end

    settle();
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
